@@ rtl/core/osrc_pkg.sv @@
// Shared constants, codes and types for the rectangle copy blitter.
package osrc_pkg;

	localparam int WIDTH = 128;
	localparam int HEIGHT = 128;
	localparam int PIXEL_BITS = 32;
	localparam int DEPTH = WIDTH * HEIGHT;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int COORD_W = 7;
	localparam int LEN_W = 8;
	localparam int SUM_W = LEN_W + 1;
	localparam int DATA_W = 32;
	localparam int OP_W = 2;

	localparam logic [OP_W-1:0] OP_READ = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
	localparam logic [OP_W-1:0] OP_MOVE = 2'd2;

	typedef struct packed {
		logic               use_src;
		logic [COORD_W-1:0] off_x;
		logic [COORD_W-1:0] off_y;
	} agu_req_t;

endpackage

@@ rtl/core/osrc_ram.sv @@
// Generic single-port RAM with registered read.
module osrc_ram #(
	parameter int DATA_W = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [DATA_W-1:0]        wdata,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

@@ rtl/core/osrc_agu.sv @@
// Shared address unit: picks a corner, adds the walk offset, forms the store address.
module osrc_agu import osrc_pkg::*; (
	input  agu_req_t            req,
	input  logic [COORD_W-1:0]  dest_x,
	input  logic [COORD_W-1:0]  dest_y,
	input  logic [COORD_W-1:0]  source_x,
	input  logic [COORD_W-1:0]  source_y,
	output logic [ADDR_W-1:0]   addr
);

	logic [COORD_W-1:0] base_x;
	logic [COORD_W-1:0] base_y;
	logic [COORD_W-1:0] pos_x;
	logic [COORD_W-1:0] pos_y;

	always_comb begin
		base_x = req.use_src ? source_x : dest_x;
		base_y = req.use_src ? source_y : dest_y;
		pos_x = base_x + req.off_x;
		pos_y = base_y + req.off_y;
		addr = ADDR_W'(pos_y) * ADDR_W'(WIDTH) + ADDR_W'(pos_x);
	end

endmodule

@@ rtl/core/overlap_safe_rect_copy.sv @@
// Top level of the rectangle copy blitter: sequencer, store and result register.
// Throughput: one word at a time; the input stalls until the result is issued and the
// next word can be taken in the cycle after; a copied pixel costs a read and a write
// on the single store port. A held result delays the next issue.
// Reset clears the sequencer and result valid; the pixel store is not cleared.
module overlap_safe_rect_copy import osrc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [OP_W-1:0]     operation,
	input  logic [COORD_W-1:0]  dest_x,
	input  logic [COORD_W-1:0]  dest_y,
	input  logic [COORD_W-1:0]  source_x,
	input  logic [COORD_W-1:0]  source_y,
	input  logic [LEN_W-1:0]    rect_width,
	input  logic [LEN_W-1:0]    rect_height,
	input  logic [DATA_W-1:0]   write_pixel,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [DATA_W-1:0]   read_pixel,
	output logic                status
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_RDATA = 3'd2;
	localparam logic [2:0] S_CRD = 3'd3;
	localparam logic [2:0] S_CWR = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]            state_q;
	logic [OP_W-1:0]       op_q;
	logic [COORD_W-1:0]    dx_q;
	logic [COORD_W-1:0]    dy_q;
	logic [COORD_W-1:0]    sx_q;
	logic [COORD_W-1:0]    sy_q;
	logic [LEN_W-1:0]      w_q;
	logic [LEN_W-1:0]      h_q;
	logic [PIXEL_BITS-1:0] wpix_q;
	logic                  down_q;
	logic                  left_q;
	logic [COORD_W-1:0]    off_x_q;
	logic [COORD_W-1:0]    off_y_q;
	logic [LEN_W-1:0]      col_left_q;
	logic [LEN_W-1:0]      row_left_q;
	logic [PIXEL_BITS-1:0] res_pix_q;
	logic                  res_st_q;
	logic                  out_valid_q;
	logic [DATA_W-1:0]     read_pixel_q;
	logic                  status_q;

	agu_req_t              agu_req;
	logic [ADDR_W-1:0]     ram_addr;
	logic                  ram_en;
	logic                  ram_we;
	logic [PIXEL_BITS-1:0] ram_rdata;

	logic                  coord_ok;
	logic                  fits;
	logic                  empty;
	logic                  down;
	logic                  left;
	logic [COORD_W-1:0]    off_x_init;
	logic [COORD_W-1:0]    w_last;
	logic [SUM_W-1:0]      sum_dx;
	logic [SUM_W-1:0]      sum_sx;
	logic [SUM_W-1:0]      sum_dy;
	logic [SUM_W-1:0]      sum_sy;
	logic                  accept;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign read_pixel = read_pixel_q;
	assign status = status_q;

	always_comb begin
		coord_ok = (int'(dx_q) < WIDTH) && (int'(dy_q) < HEIGHT);
		sum_dx = SUM_W'(dx_q) + SUM_W'(w_q);
		sum_sx = SUM_W'(sx_q) + SUM_W'(w_q);
		sum_dy = SUM_W'(dy_q) + SUM_W'(h_q);
		sum_sy = SUM_W'(sy_q) + SUM_W'(h_q);
		fits = (int'(sum_dx) <= WIDTH) && (int'(sum_sx) <= WIDTH)
			&& (int'(sum_dy) <= HEIGHT) && (int'(sum_sy) <= HEIGHT);
		empty = (w_q == '0) || (h_q == '0);
		down = dy_q > sy_q;
		left = (dy_q == sy_q) && (dx_q > sx_q);
		w_last = COORD_W'(w_q - LEN_W'(1));
		off_x_init = left_q ? w_last : '0;
	end

	always_comb begin
		agu_req.use_src = (state_q == S_CRD);
		agu_req.off_x = off_x_q;
		agu_req.off_y = off_y_q;
		if (state_q == S_DECODE) begin
			agu_req.off_x = '0;
			agu_req.off_y = '0;
		end
		ram_en = 1'b0;
		ram_we = 1'b0;
		case (state_q)
			S_DECODE: begin
				if (coord_ok && (op_q inside {OP_READ, OP_WRITE})) begin
					ram_en = 1'b1;
					ram_we = (op_q == OP_WRITE);
				end
			end
			S_CRD: begin
				ram_en = 1'b1;
			end
			S_CWR: begin
				ram_en = 1'b1;
				ram_we = 1'b1;
			end
			default: begin
				ram_en = 1'b0;
			end
		endcase
	end

	osrc_agu u_agu (
		.req      (agu_req),
		.dest_x   (dx_q),
		.dest_y   (dy_q),
		.source_x (sx_q),
		.source_y (sy_q),
		.addr     (ram_addr)
	);

	osrc_ram #(
		.DATA_W (PIXEL_BITS),
		.DEPTH  (DEPTH)
	) u_store (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata ((state_q == S_CWR) ? ram_rdata : wpix_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= operation;
			dx_q <= dest_x;
			dy_q <= dest_y;
			sx_q <= source_x;
			sy_q <= source_y;
			w_q <= rect_width;
			h_q <= rect_height;
			wpix_q <= write_pixel[PIXEL_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			down_q <= 1'b0;
			left_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					res_pix_q <= '0;
					case (op_q)
						OP_READ: begin
							res_st_q <= !coord_ok;
							state_q <= coord_ok ? S_RDATA : S_DONE;
						end
						OP_WRITE: begin
							res_st_q <= !coord_ok;
							state_q <= S_DONE;
						end
						OP_MOVE: begin
							res_st_q <= !empty && !fits;
							if (!empty && fits) begin
								down_q <= down;
								left_q <= left;
								off_x_q <= left ? w_last : '0;
								off_y_q <= down ? COORD_W'(h_q - LEN_W'(1)) : '0;
								col_left_q <= w_q - LEN_W'(1);
								row_left_q <= h_q - LEN_W'(1);
								state_q <= S_CRD;
							end else begin
								state_q <= S_DONE;
							end
						end
						default: begin
							res_st_q <= 1'b0;
							state_q <= S_DONE;
						end
					endcase
				end
				S_RDATA: begin
					res_pix_q <= ram_rdata;
					state_q <= S_DONE;
				end
				S_CRD: begin
					state_q <= S_CWR;
				end
				S_CWR: begin
					if (col_left_q != '0) begin
						col_left_q <= col_left_q - LEN_W'(1);
						off_x_q <= left_q ? off_x_q - COORD_W'(1) : off_x_q + COORD_W'(1);
						state_q <= S_CRD;
					end else if (row_left_q != '0) begin
						row_left_q <= row_left_q - LEN_W'(1);
						col_left_q <= w_q - LEN_W'(1);
						off_x_q <= off_x_init;
						off_y_q <= down_q ? off_y_q - COORD_W'(1) : off_y_q + COORD_W'(1);
						state_q <= S_CRD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						read_pixel_q <= DATA_W'(res_pix_q);
						status_q <= res_st_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ verif/osrc_result_check.sv @@
// Result checker for the rectangle copy blitter: predicts each result word and compares it.
module osrc_result_check import osrc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [OP_W-1:0]    operation,
	input  logic [COORD_W-1:0] dest_x,
	input  logic [COORD_W-1:0] dest_y,
	input  logic [COORD_W-1:0] source_x,
	input  logic [COORD_W-1:0] source_y,
	input  logic [LEN_W-1:0]   rect_width,
	input  logic [LEN_W-1:0]   rect_height,
	input  logic [DATA_W-1:0]  write_pixel,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [DATA_W-1:0]  read_pixel,
	input  logic               status,
	output int                 mismatches,
	output int                 outstanding
);

	localparam logic [1:0] ORDER_TOP_DOWN = 2'd0;
	localparam logic [1:0] ORDER_BOTTOM_UP = 2'd1;
	localparam logic [1:0] ORDER_RIGHT_TO_LEFT = 2'd2;

	typedef struct packed {
		logic [DATA_W-1:0] pixel;
		logic              flag;
	} answer_t;

	bit [PIXEL_BITS-1:0] pixels [DEPTH];
	bit [COORD_W-1:0] walk_column;
	bit [COORD_W-1:0] walk_row;
	bit [1:0] copy_order;
	answer_t pending_answers [$];
	int errors = 0;

	assign mismatches = errors;

	task automatic report(input string what);
		$display("%0t: mismatch: %s", $time, what);
		errors++;
	endtask

	function automatic void shift_pixel(int dx, int dy, int sx, int sy);
		pixels[dy * WIDTH + dx] = pixels[sy * WIDTH + sx];
		walk_column = COORD_W'(dx);
		walk_row = COORD_W'(dy);
	endfunction

	function automatic bit move_block(int dx, int dy, int sx, int sy, int w, int h);
		bit leftward;
		int off;
		if (w == 0 || h == 0)
			return 1'b1;
		if (dx + w > WIDTH || sx + w > WIDTH || dy + h > HEIGHT || sy + h > HEIGHT)
			return 1'b0;
		if (dy > sy) begin
			copy_order = ORDER_BOTTOM_UP;
			for (int r = h - 1; r >= 0; r--)
				for (int i = 0; i < w; i++)
					shift_pixel(dx + i, dy + r, sx + i, sy + r);
		end else begin
			leftward = (dy == sy) && (dx > sx);
			copy_order = leftward ? ORDER_RIGHT_TO_LEFT : ORDER_TOP_DOWN;
			for (int r = 0; r < h; r++)
				for (int i = 0; i < w; i++) begin
					off = leftward ? w - 1 - i : i;
					shift_pixel(dx + off, dy + r, sx + off, sy + r);
				end
		end
		return 1'b1;
	endfunction

	function automatic answer_t predict_answer(logic [OP_W-1:0] op, int dx, int dy, int sx,
			int sy, int w, int h, logic [DATA_W-1:0] value);
		answer_t a;
		bit in_store;
		a = '0;
		in_store = dx < WIDTH && dy < HEIGHT;
		case (op)
		OP_READ: begin
			if (in_store)
				a.pixel = DATA_W'(pixels[dy * WIDTH + dx]);
			else
				a.flag = 1'b1;
		end
		OP_WRITE: begin
			if (in_store)
				pixels[dy * WIDTH + dx] = value[PIXEL_BITS-1:0];
			else
				a.flag = 1'b1;
		end
		OP_MOVE: begin
			a.flag = !move_block(dx, dy, sx, sy, w, h);
		end
		default: ;
		endcase
		return a;
	endfunction

	always @(posedge clk) begin
		answer_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_answers.size() == 0) begin
					report("result word with no word outstanding");
				end else begin
					want = pending_answers.pop_front();
					if (read_pixel !== want.pixel)
						report($sformatf("read_pixel %h, expected %h", read_pixel, want.pixel));
					if (status !== want.flag)
						report($sformatf("status %b, expected %b", status, want.flag));
				end
			end
			if (in_valid && !in_stall)
				pending_answers.push_back(predict_answer(operation, int'(dest_x),
					int'(dest_y), int'(source_x), int'(source_y), int'(rect_width),
					int'(rect_height), write_pixel));
			outstanding <= pending_answers.size();
		end
	end

	initial outstanding = 0;

endmodule

@@ verif/tb_overlap_safe_rect_copy.sv @@
// Testbench top for the rectangle copy blitter: drives command words and gives the verdict.
module tb_overlap_safe_rect_copy;
	import osrc_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
	localparam int RANDOM_WORDS = 1250;
	localparam int WATCHDOG_LIMIT = 150000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int HOLD_OFF_AT = 300;
	localparam int REGION = 16;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [COORD_W-1:0] dx;
		logic [COORD_W-1:0] dy;
		logic [COORD_W-1:0] sx;
		logic [COORD_W-1:0] sy;
		logic [LEN_W-1:0]   w;
		logic [LEN_W-1:0]   h;
		logic [DATA_W-1:0]  value;
	} blit_word_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [OP_W-1:0] operation;
	logic [COORD_W-1:0] dest_x;
	logic [COORD_W-1:0] dest_y;
	logic [COORD_W-1:0] source_x;
	logic [COORD_W-1:0] source_y;
	logic [LEN_W-1:0] rect_width;
	logic [LEN_W-1:0] rect_height;
	logic [DATA_W-1:0] write_pixel;
	logic out_valid;
	logic out_stall;
	logic [DATA_W-1:0] read_pixel;
	logic status;
	int mismatches;
	int outstanding;
	int idle_cycles;
	int sent = 0;

	bit defined_px [DEPTH];
	int written_cells [$];

	overlap_safe_rect_copy dut (.*);
	osrc_result_check result_check (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	function automatic int cell_of(int x, int y);
		return y * WIDTH + x;
	endfunction

	function automatic blit_word_t word_of(logic [OP_W-1:0] op, logic [COORD_W-1:0] dx,
			logic [COORD_W-1:0] dy, logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
			logic [LEN_W-1:0] w, logic [LEN_W-1:0] h, logic [DATA_W-1:0] value);
		blit_word_t b;
		b.op = op;
		b.dx = dx;
		b.dy = dy;
		b.sx = sx;
		b.sy = sy;
		b.w = w;
		b.h = h;
		b.value = value;
		return b;
	endfunction

	// track which pixels hold a defined value, so reads never hit an unwritten one
	function automatic void track_word(blit_word_t b);
		bit snapshot [];
		int w;
		int h;
		w = int'(b.w);
		h = int'(b.h);
		if (b.op == OP_WRITE) begin
			defined_px[cell_of(int'(b.dx), int'(b.dy))] = 1'b1;
			written_cells.push_back(cell_of(int'(b.dx), int'(b.dy)));
		end else if (b.op == OP_MOVE && w > 0 && h > 0 && b.dx + w <= WIDTH
				&& b.sx + w <= WIDTH && b.dy + h <= HEIGHT && b.sy + h <= HEIGHT) begin
			snapshot = new[w * h];
			for (int r = 0; r < h; r++)
				for (int i = 0; i < w; i++)
					snapshot[r * w + i] = defined_px[cell_of(b.sx + i, b.sy + r)];
			for (int r = 0; r < h; r++)
				for (int i = 0; i < w; i++)
					defined_px[cell_of(b.dx + i, b.dy + r)] = snapshot[r * w + i];
		end
	endfunction

	function automatic blit_word_t pick_word();
		blit_word_t b;
		int roll;
		int found;
		int cand;
		roll = $urandom_range(0, 99);
		b.op = OP_SPARE;
		b.dx = COORD_W'($urandom_range(0, 127));
		b.dy = COORD_W'($urandom_range(0, 127));
		b.sx = COORD_W'($urandom_range(0, 127));
		b.sy = COORD_W'($urandom_range(0, 127));
		b.w = LEN_W'($urandom_range(0, 128));
		b.h = LEN_W'($urandom_range(0, 128));
		b.value = $urandom;
		if (roll < 30) begin
			b.op = OP_WRITE;
			if ($urandom_range(0, 4) != 0) begin
				b.dx = COORD_W'($urandom_range(0, REGION + 7));
				b.dy = COORD_W'($urandom_range(0, REGION + 7));
			end
		end else if (roll < 60) begin
			found = -1;
			for (int tries = 0; tries < 8; tries++) begin
				if ($urandom_range(0, 4) != 0 || written_cells.size() == 0)
					cand = cell_of($urandom_range(0, REGION + 7), $urandom_range(0, REGION + 7));
				else
					cand = written_cells[$urandom_range(0, written_cells.size() - 1)];
				if (defined_px[cand]) begin
					found = cand;
					break;
				end
			end
			if (found >= 0) begin
				b.op = OP_READ;
				b.dx = COORD_W'(found % WIDTH);
				b.dy = COORD_W'(found / WIDTH);
			end else begin
				b.op = OP_WRITE;
				b.dx = COORD_W'($urandom_range(0, REGION + 7));
				b.dy = COORD_W'($urandom_range(0, REGION + 7));
			end
		end else if (roll < 92) begin
			b.op = OP_MOVE;
			if ($urandom_range(0, 4) != 0) begin
				b.dx = COORD_W'($urandom_range(0, REGION - 1));
				b.dy = COORD_W'($urandom_range(0, REGION - 1));
				b.sx = COORD_W'($urandom_range(0, REGION - 1));
				b.sy = COORD_W'($urandom_range(0, REGION - 1));
				b.w = LEN_W'($urandom_range(1, 8));
				b.h = LEN_W'($urandom_range(1, 8));
			end else if (b.dx + b.w <= WIDTH && b.sx + b.w <= WIDTH && b.dy + b.h <= HEIGHT
					&& b.sy + b.h <= HEIGHT && b.w * b.h > 512) begin
				b.h = 1;
			end
		end
		return b;
	endfunction

	task automatic send_word(input blit_word_t b);
		int gap;
		gap = ((sent / 100) % 5 == 4) ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= b.op;
		dest_x <= b.dx;
		dest_y <= b.dy;
		source_x <= b.sx;
		source_y <= b.sy;
		rect_width <= b.w;
		rect_height <= b.h;
		write_pixel <= b.value;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		track_word(b);
		sent++;
	endtask

	initial begin
		int gap;
		int taken;
		taken = 0;
		out_stall <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			gap = ((taken / 80) % 4 == 3) ? 0 : $urandom_range(0, 4);
			if (taken == HOLD_OFF_AT)
				gap = HOLD_OFF_CYCLES;
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			taken++;
		end
	end

	initial begin
		blit_word_t directed [$];
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		operation <= OP_READ;
		dest_x <= '0;
		dest_y <= '0;
		source_x <= '0;
		source_y <= '0;
		rect_width <= '0;
		rect_height <= '0;
		write_pixel <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed.push_back(word_of(OP_WRITE, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
		directed.push_back(word_of(OP_WRITE, 127, 127, 0, 0, 0, 0, 32'h0000_0000));
		directed.push_back(word_of(OP_WRITE, 127, 0, 0, 0, 0, 0, 32'hA5A5_5A5A));
		directed.push_back(word_of(OP_WRITE, 0, 127, 0, 0, 0, 0, 32'h5A5A_A5A5));
		directed.push_back(word_of(OP_READ, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(word_of(OP_READ, 127, 127, 0, 0, 0, 0, 0));
		directed.push_back(word_of(OP_READ, 0, 127, 0, 0, 0, 0, 0));
		directed.push_back(word_of(OP_SPARE, 127, 127, 127, 127, 128, 128, 32'hFFFF_FFFF));
		directed.push_back(word_of(OP_MOVE, 5, 5, 0, 0, 0, 5, 0));
		directed.push_back(word_of(OP_MOVE, 5, 5, 0, 0, 5, 0, 0));
		directed.push_back(word_of(OP_MOVE, 1, 0, 0, 0, 128, 1, 0));
		directed.push_back(word_of(OP_MOVE, 0, 0, 0, 1, 1, 128, 0));
		directed.push_back(word_of(OP_MOVE, 127, 0, 0, 0, 1, 1, 0));
		directed.push_back(word_of(OP_READ, 127, 0, 0, 0, 0, 0, 0));
		directed.push_back(word_of(OP_WRITE, 10, 10, 0, 0, 0, 0, 32'h1111_1111));
		directed.push_back(word_of(OP_WRITE, 11, 10, 0, 0, 0, 0, 32'h2222_2222));
		directed.push_back(word_of(OP_WRITE, 12, 10, 0, 0, 0, 0, 32'h3333_3333));
		directed.push_back(word_of(OP_MOVE, 11, 10, 10, 10, 2, 1, 0));
		directed.push_back(word_of(OP_MOVE, 10, 11, 10, 10, 3, 1, 0));
		directed.push_back(word_of(OP_MOVE, 10, 10, 11, 11, 2, 1, 0));
		directed.push_back(word_of(OP_MOVE, 10, 10, 11, 10, 2, 1, 0));
		directed.push_back(word_of(OP_READ, 10, 10, 0, 0, 0, 0, 0));
		directed.push_back(word_of(OP_READ, 12, 10, 0, 0, 0, 0, 0));
		directed.push_back(word_of(OP_READ, 11, 11, 0, 0, 0, 0, 0));
		directed.push_back(word_of(OP_MOVE, 0, 0, 0, 0, 128, 128, 0));

		foreach (directed[k])
			send_word(directed[k]);
		repeat (RANDOM_WORDS)
			send_word(pick_word());
		in_valid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/osrc_pkg.sv
rtl/core/osrc_ram.sv
rtl/core/osrc_agu.sv
rtl/core/overlap_safe_rect_copy.sv
verif/osrc_result_check.sv
verif/tb_overlap_safe_rect_copy.sv
